@@ rtl/ils_pkg.sv @@
// shared types, constants and codes for the indexed list store
`timescale 1ns / 1ps
package ils_pkg;
	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int COUNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W      = 9;
	localparam int CMD_W      = 3;
	localparam int ST_W       = 2;
	localparam int GROUP      = 16;
	localparam int NGROUP     = CAPACITY / GROUP;
	localparam int GIDX_W     = $clog2(GROUP);
	localparam int GSEL_W     = $clog2(NGROUP);

	localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_WRITE = 2'd1;
	localparam logic [1:0] CELL_UP    = 2'd2;
	localparam logic [1:0] CELL_DOWN  = 2'd3;

	typedef struct packed {
		logic [1:0]            op;
		logic [IDX_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] wdata;
	} cell_ctl_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] key;
		logic [COUNT_W-1:0]    limit;
	} cell_srch_t;
endpackage

@@ rtl/ils_cell.sv @@
// one list cell: holds one entry, shifts with its neighbors, compares against the key
`timescale 1ns / 1ps
module ils_cell (
	input  logic                          clk,
	input  ils_pkg::cell_ctl_t            ctl,
	input  ils_pkg::cell_srch_t           srch,
	input  logic [ils_pkg::IDX_W-1:0]      idx,
	input  logic [ils_pkg::DATA_WIDTH-1:0] left_entry,
	input  logic [ils_pkg::DATA_WIDTH-1:0] right_entry,
	output logic [ils_pkg::DATA_WIDTH-1:0] entry,
	output logic                          hit
);
	import ils_pkg::*;

	logic [DATA_WIDTH-1:0] entry_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_WRITE: begin
				if (idx == ctl.pos) entry_q <= ctl.wdata;
			end
			CELL_UP: begin
				if (idx == ctl.pos) entry_q <= ctl.wdata;
				else if (idx > ctl.pos) entry_q <= left_entry;
			end
			CELL_DOWN: begin
				if (idx >= ctl.pos) entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	// only live entries may match
	assign hit = (entry_q == srch.key) && ({1'b0, idx} < COUNT_W'(srch.limit));
endmodule

@@ rtl/ils_group.sv @@
// first-match encoder and read mux over one group of cells, registered
`timescale 1ns / 1ps
module ils_group (
	input  logic                                        clk,
	input  logic [ils_pkg::GROUP-1:0][ils_pkg::DATA_WIDTH-1:0] entries,
	input  logic [ils_pkg::GROUP-1:0]                   hits,
	input  logic [ils_pkg::GIDX_W-1:0]                  sel,
	output logic                                        any_s2,
	output logic [ils_pkg::GIDX_W-1:0]                  first_s2,
	output logic [ils_pkg::DATA_WIDTH-1:0]               rdata_s2
);
	import ils_pkg::*;

	logic [GIDX_W-1:0] first_c;

	always_comb begin
		first_c = '0;
		for (int i = GROUP - 1; i >= 0; i--) begin
			if (hits[i]) first_c = GIDX_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		any_s2   <= |hits;
		first_s2 <= first_c;
		rdata_s2 <= entries[sel];
	end
endmodule

@@ rtl/indexed_list_store_top.sv @@
// top level of the indexed list store: command decode, cell row and result stages
`timescale 1ns / 1ps
// indexed list store, a fixed-capacity ordered list held in a row of cells
// command channel: an item (cmd, position, item_value) is taken on a rising edge
//   with start high and busy low; busy is high while a command is in flight
// commands: get, set, insert (shift later entries up), erase (shift later entries
//   down), find (lowest matching position), clear
// set, insert and erase change the cells at the accepting edge itself:
//   each cell that changes loads from its neighbor or the write data at that edge
// clear only zeroes the entry count at that edge
// result: done is high for exactly one cycle with read_value, found,
//   found_position, status and count; the receiver cannot hold it off
// after acceptance a command passes stage 1, stage 2 and the result registers;
//   busy is high while it is in stage 1 or 2, and no new item is taken meanwhile
// stages 1 and 2 are the registered search/read tree: per-group first match and
//   read mux over 16 cells, then a choice over the 16 groups
// reset: entry count goes to zero and the pipeline empties; cell contents are not
//   cleared, only entries below the count are ever read or matched
// a new command may be accepted in the same cycle that done is shown
module indexed_list_store_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ils_pkg::CMD_W-1:0]      cmd,
	input  logic [ils_pkg::POS_W-1:0]      position,
	input  logic [ils_pkg::DATA_WIDTH-1:0] item_value,
	output logic                        done,
	output logic [ils_pkg::DATA_WIDTH-1:0] read_value,
	output logic                        found,
	output logic [ils_pkg::IDX_W-1:0]      found_position,
	output logic [ils_pkg::ST_W-1:0]       status,
	output logic [ils_pkg::COUNT_W-1:0]    count
);
	import ils_pkg::*;

	// state
	logic [COUNT_W-1:0] count_q;

	// stage 1: command in the search/read tree
	logic                  v_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [IDX_W-1:0]      pos_s1;
	logic [DATA_WIDTH-1:0] key_s1;
	logic [ST_W-1:0]       st_s1;
	logic [COUNT_W-1:0]    cnt_s1;

	// stage 2: group results ready
	logic               v_s2;
	logic [CMD_W-1:0]   cmd_s2;
	logic [GSEL_W-1:0]  gsel_s2;
	logic [ST_W-1:0]    st_s2;
	logic [COUNT_W-1:0] cnt_s2;

	// result registers
	logic                  done_q;
	logic [DATA_WIDTH-1:0] read_value_q;
	logic                  found_q;
	logic [IDX_W-1:0]      found_position_q;
	logic [ST_W-1:0]       status_q;
	logic [COUNT_W-1:0]    count_out_q;

	logic                  accept;
	logic [1:0]            op_c;
	logic [ST_W-1:0]       st_c;
	logic [COUNT_W-1:0]    cnt_c;
	logic                  in_range;
	logic                  ins_range;
	logic                  full;
	cell_ctl_t             ctl;
	cell_srch_t            srch;

	logic [CAPACITY-1:0][DATA_WIDTH-1:0] entry_w;
	logic [CAPACITY-1:0]                 hit_w;

	logic [NGROUP-1:0]                   grp_any_s2;
	logic [NGROUP-1:0][GIDX_W-1:0]       grp_first_s2;
	logic [NGROUP-1:0][DATA_WIDTH-1:0]   grp_rd_s2;

	logic                  any_c;
	logic [GSEL_W-1:0]     gfirst_c;

	assign accept = start && !busy;
	assign busy   = v_s1 || v_s2;

	// position checks against the count before the command
	assign in_range  = COUNT_W'(position) < count_q && position < POS_W'(CAPACITY);
	assign ins_range = COUNT_W'(position) <= count_q && position <= POS_W'(CAPACITY);
	assign full      = count_q == COUNT_W'(CAPACITY);

	// command decode: status, new count and what the cells do
	always_comb begin
		op_c  = CELL_HOLD;
		st_c  = ST_OK;
		cnt_c = count_q;
		unique case (cmd)
			CMD_GET: begin
				if (!in_range) st_c = ST_RANGE;
			end
			CMD_SET: begin
				if (in_range) op_c = CELL_WRITE;
				else st_c = ST_RANGE;
			end
			CMD_INSERT: begin
				if (!ins_range) st_c = ST_RANGE;
				else if (full) st_c = ST_FULL;
				else begin
					op_c  = CELL_UP;
					cnt_c = count_q + COUNT_W'(1);
				end
			end
			CMD_ERASE: begin
				if (in_range) begin
					op_c  = CELL_DOWN;
					cnt_c = count_q - COUNT_W'(1);
				end else st_c = ST_RANGE;
			end
			CMD_CLEAR: begin
				cnt_c = '0;
			end
			default: begin
				// find and unused codes leave the cells alone
				op_c = CELL_HOLD;
			end
		endcase
	end

	// cells act only on the accepting edge
	assign ctl.op    = accept ? op_c : CELL_HOLD;
	assign ctl.pos   = position[IDX_W-1:0];
	assign ctl.wdata = item_value;

	// search runs in stage 1 against the settled cells
	assign srch.key   = key_s1;
	assign srch.limit = cnt_s1;

	// row of cells, each handing its entry to both neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = entry_w[g+1];
		end
		ils_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.srch        (srch),
			.idx         (IDX_W'(g)),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (entry_w[g]),
			.hit         (hit_w[g])
		);
	end

	// first level of the tree: one encoder and read mux per group of cells
	for (genvar k = 0; k < NGROUP; k++) begin : g_grp
		ils_group u_grp (
			.clk      (clk),
			.entries  (entry_w[k*GROUP +: GROUP]),
			.hits     (hit_w[k*GROUP +: GROUP]),
			.sel      (pos_s1[GIDX_W-1:0]),
			.any_s2   (grp_any_s2[k]),
			.first_s2 (grp_first_s2[k]),
			.rdata_s2 (grp_rd_s2[k])
		);
	end

	// second level: lowest group with a match
	always_comb begin
		gfirst_c = '0;
		for (int k = NGROUP - 1; k >= 0; k--) begin
			if (grp_any_s2[k]) gfirst_c = GSEL_W'(k);
		end
	end
	assign any_c = |grp_any_s2;

	// control state and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (accept) count_q <= cnt_c;
			v_s1   <= accept;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			pos_s1 <= position[IDX_W-1:0];
			key_s1 <= item_value;
			st_s1  <= st_c;
			cnt_s1 <= cnt_c;
		end
		cmd_s2  <= cmd_s1;
		gsel_s2 <= pos_s1[IDX_W-1:GIDX_W];
		st_s2   <= st_s1;
		cnt_s2  <= cnt_s1;
	end

	// result registers: fields are zero unless their command produced them
	always_ff @(posedge clk) begin
		if (v_s2) begin
			read_value_q     <= (cmd_s2 == CMD_GET && st_s2 == ST_OK) ?
			                    grp_rd_s2[gsel_s2] : '0;
			found_q          <= (cmd_s2 == CMD_FIND) && any_c;
			found_position_q <= (cmd_s2 == CMD_FIND && any_c) ?
			                    {gfirst_c, grp_first_s2[gfirst_c]} : '0;
			status_q         <= st_s2;
			count_out_q      <= cnt_s2;
		end
	end

	assign done           = done_q;
	assign read_value     = read_value_q;
	assign found          = found_q;
	assign found_position = found_position_q;
	assign status         = status_q;
	assign count          = count_out_q;
endmodule

@@ rtl/ils_checker.sv @@
// port-level checks for the indexed list store, bound to the top level
`timescale 1ns / 1ps
module ils_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [ils_pkg::DATA_WIDTH-1:0] read_value,
	input logic                        found,
	input logic [ils_pkg::ST_W-1:0]       status,
	input logic [ils_pkg::COUNT_W-1:0]    count
);
	import ils_pkg::*;

	// an accepted item keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	// fixed latency from acceptance to result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result not delivered three cycles after acceptance");

	// the pipeline is empty while a result is shown
	a_idle_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result is shown");

	// a find hit is a clean status with no read data
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK && read_value == '0)
		else $error("find hit with bad status or read data");

	// full only when the list is at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> count == COUNT_W'(CAPACITY))
		else $error("full status below capacity");
endmodule

bind indexed_list_store_top ils_checker u_ils_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.read_value (read_value),
	.found      (found),
	.status     (status),
	.count      (count)
);

@@ tb/indexed_list_store_checker.sv @@
// result checker for the indexed list store: tracks the list and compares every result
`timescale 1ns / 1ps
module indexed_list_store_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [ils_pkg::CMD_W-1:0]      cmd,
	input  logic [ils_pkg::POS_W-1:0]      position,
	input  logic [ils_pkg::DATA_WIDTH-1:0] item_value,
	input  logic                           done,
	input  logic [ils_pkg::DATA_WIDTH-1:0] read_value,
	input  logic                           found,
	input  logic [ils_pkg::IDX_W-1:0]      found_position,
	input  logic [ils_pkg::ST_W-1:0]       status,
	input  logic [ils_pkg::COUNT_W-1:0]    count,
	output int unsigned                    errors,
	output int unsigned                    pending,
	output int unsigned                    checked
);
	import ils_pkg::*;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_value;
		logic                  found;
		logic [IDX_W-1:0]      found_position;
		logic [ST_W-1:0]       status;
		logic [COUNT_W-1:0]    count;
	} list_result_t;

	logic [DATA_WIDTH-1:0] list_entries [CAPACITY];
	int                    list_len = 0;
	list_result_t          expected_results [$];
	int unsigned           error_total = 0;
	int unsigned           result_total = 0;
	int unsigned           reported = 0;

	// applies one command to the tracked list and returns the result it must give
	function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] c,
			input logic [POS_W-1:0] p, input logic [DATA_WIDTH-1:0] v);
		list_result_t r;
		int           i;
		r = '0;
		case (c)
			CMD_GET: begin
				if (p < list_len)
					r.read_value = list_entries[p];
				else
					r.status = ST_RANGE;
			end
			CMD_SET: begin
				if (p < list_len)
					list_entries[p] = v;
				else
					r.status = ST_RANGE;
			end
			CMD_INSERT: begin
				if (p > list_len) begin
					r.status = ST_RANGE;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > p; i--)
						list_entries[i] = list_entries[i-1];
					list_entries[p] = v;
					list_len++;
				end
			end
			CMD_ERASE: begin
				if (p < list_len) begin
					for (i = p; i + 1 < list_len; i++)
						list_entries[i] = list_entries[i+1];
					list_len--;
				end else begin
					r.status = ST_RANGE;
				end
			end
			CMD_FIND: begin
				for (i = 0; i < list_len; i++) begin
					if (list_entries[i] == v) begin
						r.found = 1'b1;
						r.found_position = i[IDX_W-1:0];
						break;
					end
				end
			end
			CMD_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
		end else begin
			// results first, so a command taken in the same cycle queues behind them
			if (done) begin
				got = {read_value, found, found_position, status, count};
				if (expected_results.size() == 0) begin
					error_total++;
					if (reported < 10)
						$display("unexpected result at %0t: rd=%h found=%0b fpos=%0d st=%0d cnt=%0d",
							$realtime, got.read_value, got.found, got.found_position,
							got.status, got.count);
					reported++;
				end else begin
					want = expected_results.pop_front();
					result_total++;
					if (got !== want) begin
						error_total++;
						if (reported < 10) begin
							$display("mismatch at %0t: want rd=%h found=%0b fpos=%0d st=%0d cnt=%0d",
								$realtime, want.read_value, want.found, want.found_position,
								want.status, want.count);
							$display("                    got  rd=%h found=%0b fpos=%0d st=%0d cnt=%0d",
								got.read_value, got.found, got.found_position,
								got.status, got.count);
						end
						reported++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_list_command(cmd, position, item_value));
		end
		errors  <= error_total;
		pending <= expected_results.size();
		checked <= result_total;
	end
endmodule

@@ tb/testbench.sv @@
// testbench top for the indexed list store: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps
module testbench;
	import ils_pkg::*;

	// the two command codes the block ignores
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 1225;
	localparam int CALM_TAIL    = 150;      // final items sent back to back
	localparam int CYCLE_LIMIT  = 200000;

	// the random part walks through these, so the list fills up, drains and churns
	typedef enum logic [1:0] {PH_GROW, PH_MIX, PH_SHRINK, PH_CHURN} stim_phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [CMD_W-1:0]      cmd = CMD_GET;
	logic [POS_W-1:0]      position = '0;
	logic [DATA_WIDTH-1:0] item_value = '0;
	logic                  busy;
	logic                  done;
	logic [DATA_WIDTH-1:0] read_value;
	logic                  found;
	logic [IDX_W-1:0]      found_position;
	logic [ST_W-1:0]       status;
	logic [COUNT_W-1:0]    count;

	int unsigned errors;
	int unsigned pending;
	int unsigned checked;

	// rough list length, kept to aim positions at the live part of the list and to report its peak
	int          list_len = 0;
	int          peak_len = 0;
	int unsigned full_refusals = 0;
	int unsigned sent_by_cmd [8];
	int unsigned cycles = 0;
	logic [DATA_WIDTH-1:0] value_pool [8];

	indexed_list_store_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.read_value     (read_value),
		.found          (found),
		.found_position (found_position),
		.status         (status),
		.count          (count)
	);

	indexed_list_store_checker list_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.read_value     (read_value),
		.found          (found),
		.found_position (found_position),
		.status         (status),
		.count          (count),
		.errors         (errors),
		.pending        (pending),
		.checked        (checked)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: a hang or a lost result ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// present one item and hold it until the block takes it
	task automatic issue(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
			input logic [DATA_WIDTH-1:0] v);
		start      <= 1'b1;
		cmd        <= c;
		position   <= p;
		item_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// taken at this edge; follow the length change for position aiming
		sent_by_cmd[c]++;
		case (c)
			CMD_INSERT: begin
				if (p <= list_len) begin
					if (list_len < CAPACITY)
						list_len++;
					else
						full_refusals++;
				end
			end
			CMD_ERASE: begin
				if (p < list_len)
					list_len--;
			end
			CMD_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	// sender gap: start low for a burst of cycles
	task automatic rest(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [CMD_W-1:0] pick_cmd(input stim_phase_t ph);
		int roll;
		roll = $urandom_range(0, 99);
		// spare codes share the leftover slice of each phase
		case (ph)
			PH_GROW: begin
				if (roll < 88) return CMD_INSERT;
				if (roll < 90) return CMD_ERASE;
				if (roll < 93) return CMD_GET;
				if (roll < 95) return CMD_SET;
				if (roll < 98) return CMD_FIND;
			end
			PH_MIX: begin
				if (roll < 22) return CMD_INSERT;
				if (roll < 42) return CMD_ERASE;
				if (roll < 57) return CMD_GET;
				if (roll < 72) return CMD_SET;
				if (roll < 97) return CMD_FIND;
			end
			PH_SHRINK: begin
				if (roll < 3)  return CMD_INSERT;
				if (roll < 88) return CMD_ERASE;
				if (roll < 92) return CMD_GET;
				if (roll < 95) return CMD_SET;
				if (roll < 98) return CMD_FIND;
			end
			default: begin
				if (roll < 30) return CMD_INSERT;
				if (roll < 50) return CMD_ERASE;
				if (roll < 62) return CMD_GET;
				if (roll < 74) return CMD_SET;
				if (roll < 92) return CMD_FIND;
				if (roll < 95) return CMD_CLEAR;
			end
		endcase
		return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
	endfunction

	// mostly positions inside the list (or the append slot), sometimes anything
	function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] c);
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, (1 << POS_W) - 1);
		if (c == CMD_INSERT)
			return $urandom_range(0, list_len);
		if (list_len == 0)
			return '0;
		return $urandom_range(0, list_len - 1);
	endfunction

	// half the values come from a small pool so finds hit and duplicates appear
	function automatic logic [DATA_WIDTH-1:0] pick_value();
		if ($urandom_range(0, 1) == 0)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	initial begin
		stim_phase_t      ph;
		logic [CMD_W-1:0] c;
		int               n;
		foreach (sent_by_cmd[k])
			sent_by_cmd[k] = 0;
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int k = 2; k < 8; k++)
			value_pool[k] = $urandom;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list first, so get and erase are out of range and find misses
		issue(CMD_GET, 9'd0, 32'h0);
		issue(CMD_ERASE, 9'd0, 32'h0);
		issue(CMD_FIND, 9'd0, 32'h0);
		// insert one past the end is a range error
		issue(CMD_INSERT, 9'd1, 32'hDEADBEEF);
		// build [5a5a5a5a, ffffffff, ffffffff, 0]: append, front and middle inserts
		issue(CMD_INSERT, 9'd0, 32'hFFFFFFFF);
		issue(CMD_INSERT, 9'd1, 32'h00000000);
		issue(CMD_INSERT, 9'd0, 32'h5A5A5A5A);
		issue(CMD_INSERT, 9'd1, 32'hFFFFFFFF);
		// reads at both ends and just past the end
		issue(CMD_GET, 9'd0, 32'h0);
		issue(CMD_GET, 9'd3, 32'h0);
		issue(CMD_GET, 9'd4, 32'h0);
		// duplicate value: lowest position must win
		issue(CMD_FIND, 9'd0, 32'hFFFFFFFF);
		issue(CMD_FIND, 9'd511, 32'h00000000);
		issue(CMD_SET, 9'd3, 32'h80000001);
		issue(CMD_SET, 9'd4, 32'h12345678);
		issue(CMD_SET, 9'd511, 32'hFFFFFFFF);
		// erase at the front, then the last entry
		issue(CMD_ERASE, 9'd0, 32'h0);
		issue(CMD_ERASE, 9'd2, 32'h0);
		issue(CMD_GET, 9'd511, 32'h0);
		// spare codes carry junk fields and must change nothing
		issue(CMD_SPARE_LO, 9'd511, 32'hFFFFFFFF);
		issue(CMD_SPARE_HI, 9'd0, 32'hA5A5A5A5);
		issue(CMD_CLEAR, 9'd37, 32'h0);
		issue(CMD_GET, 9'd0, 32'h0);
		issue(CMD_INSERT, 9'd0, 32'h12345678);
		issue(CMD_FIND, 9'd0, 32'h12345678);

		// random: fill to the full limit, mix, drain to empty, refill, churn
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n < 360)
				ph = PH_GROW;
			else if (n < 500)
				ph = PH_MIX;
			else if (n < 860)
				ph = PH_SHRINK;
			else if (n < 1000)
				ph = PH_GROW;
			else
				ph = PH_CHURN;
			// gaps come in bursts, with every third window of 64 items left busy
			if (n < RANDOM_ITEMS - CALM_TAIL && (n / 64) % 3 != 2 &&
					$urandom_range(0, 7) == 0)
				rest($urandom_range(1, 17));
			c = pick_cmd(ph);
			issue(c, pick_position(c), pick_value());
		end
		start <= 1'b0;

		// drain: the checker's pending count is registered, so wait for an edge before looking
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d get, %0d set, %0d insert, %0d erase, %0d find, %0d clear, %0d spare",
			sent_by_cmd[CMD_GET], sent_by_cmd[CMD_SET], sent_by_cmd[CMD_INSERT],
			sent_by_cmd[CMD_ERASE], sent_by_cmd[CMD_FIND], sent_by_cmd[CMD_CLEAR],
			sent_by_cmd[CMD_SPARE_LO] + sent_by_cmd[CMD_SPARE_HI]);
		$display("%0d results checked, list peaked at %0d entries, %0d inserts refused as full",
			checked, peak_len, full_refusals);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
